// ===== hdl/sgmu_pkg.sv =====
// sgmu_pkg: request kinds and status codes of the segmented memory unit
// no dependencies; used by segmented_memory_unit and its checker
package sgmu_pkg;

   typedef enum logic [2:0] {
      OP_MAP      = 3'd0,
      OP_UNMAP    = 3'd1,
      OP_READ     = 3'd2,
      OP_WRITE    = 3'd3,
      OP_COPY     = 3'd4,
      OP_VALIDATE = 3'd5
   } op_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BADSEG  = 3'd1;
   localparam logic [2:0] ST_BADADDR = 3'd2;
   localparam logic [2:0] ST_BADSIZE = 3'd3;
   localparam logic [2:0] ST_NOID    = 3'd4;

endpackage

// ===== hdl/segmented_memory_unit.sv =====
// segmented_memory_unit: segment table, free id ring and word store with a
// sequencer, one word per step (a step pair in copy); depends on sgmu_pkg
//
//   channel   ports                              transfer
//   request   start, busy, req_*                 start high while busy low
//   result    rsp_valid, rsp_rd_data, rsp_status one cycle strobe, no stall
//
// each request steps S_SZA, S_SZB, S_EXEC; result strobe as busy falls
// validate, unmap, bad: end at S_EXEC; write: S_WRW; read: S_RDA, S_RDD
// map: S_CLR walk over size words; copy: S_CPR, S_CPW pair per source word
// one word store port pair sets the walk length; busy stays high throughout
// synchronous active-high reset clears control state only, no clearing pass
module segmented_memory_unit #(
   parameter int MAX_SEGS  = 64,
   parameter int MAX_WORDS = 256,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_seg_id,
   input  logic [31:0] req_src_seg,
   input  logic [31:0] req_word_addr,
   input  logic [31:0] req_wr_value,
   input  logic [31:0] req_seg_size,
   output logic        rsp_valid,
   output logic [31:0] rsp_rd_data,
   output logic [2:0]  rsp_status
);

   localparam int     SEG_W = $clog2(MAX_SEGS);
   localparam int     SZ_W  = $clog2(MAX_WORDS + 1);
   localparam longint DEPTH = longint'(MAX_SEGS) * longint'(MAX_WORDS);
   localparam int     ST_W  = $clog2(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_SZA, S_SZB, S_EXEC, S_CLR, S_CPR, S_CPW, S_RDA, S_RDD, S_WRW
   } state_type;

   state_type            state_ff;
   logic [2:0]           op_ff;
   logic [31:0]          seg_ff, src_ff, addr_ff, val_ff, size_ff;
   logic [SZ_W-1:0]      size_a_ff;
   logic [SEG_W-1:0]     head_ff;
   logic [SEG_W:0]       count_ff, fresh_ff;
   logic [ST_W-1:0]      dst_base_ff, src_base_ff;
   logic [SZ_W-1:0]      off_ff, len_ff;

   logic [SZ_W-1:0]      size_mem [MAX_SEGS];
   logic [SEG_W-1:0]     fifo_mem [MAX_SEGS];
   logic [WORD_BITS-1:0] word_mem [DEPTH];
   logic [SZ_W-1:0]      size_q;
   logic [SEG_W-1:0]     fifo_q;
   logic [WORD_BITS-1:0] word_q;

   logic                 seg_known, src_known;
   logic [SEG_W-1:0]     seg_idx, src_idx, size_rd_idx, tail_idx, map_id;
   logic [SEG_W+1:0]     tail_sum;
   logic [ST_W-1:0]      word_rd_addr, word_wr_addr;
   logic                 size_we, fifo_we, word_we;
   logic [SEG_W-1:0]     size_wr_idx;
   logic [SZ_W-1:0]      size_wr_data;
   logic [WORD_BITS-1:0] word_wr_data;
   logic                 map_bad_size, map_from_fifo, map_from_fresh;

   assign seg_known   = seg_ff < 32'(fresh_ff);
   assign src_known   = src_ff < 32'(fresh_ff);
   assign seg_idx     = seg_ff[SEG_W-1:0];
   assign src_idx     = src_ff[SEG_W-1:0];
   assign size_rd_idx = (state_ff == S_SZB) ? src_idx : seg_idx;
   assign tail_sum    = (SEG_W+2)'(head_ff) + (SEG_W+2)'(count_ff);
   assign tail_idx    = (tail_sum >= (SEG_W+2)'(MAX_SEGS))
                        ? SEG_W'(tail_sum - (SEG_W+2)'(MAX_SEGS)) : SEG_W'(tail_sum);

   assign map_bad_size   = (size_ff == 32'd0) || (size_ff > 32'(MAX_WORDS));
   assign map_from_fifo  = count_ff != '0;
   assign map_from_fresh = fresh_ff < (SEG_W+1)'(MAX_SEGS);
   assign map_id         = map_from_fifo ? fifo_q : SEG_W'(fresh_ff);

   assign word_rd_addr = (state_ff == S_CPR) ? src_base_ff + ST_W'(off_ff)
                                             : dst_base_ff + ST_W'(off_ff);
   assign word_wr_addr = dst_base_ff + ST_W'(off_ff);
   assign word_we      = (state_ff == S_CLR && off_ff != len_ff) || state_ff == S_CPW
                         || state_ff == S_WRW;
   assign word_wr_data = (state_ff == S_CPW) ? word_q
                       : (state_ff == S_WRW) ? WORD_BITS'(val_ff) : '0;

   // size table and free ring writes happen only in the decision step
   always_comb begin
      size_we      = 1'b0;
      size_wr_idx  = seg_idx;
      size_wr_data = '0;
      fifo_we      = 1'b0;
      if (state_ff == S_EXEC) begin
         case (op_ff)
            sgmu_pkg::OP_MAP: begin
               if (!map_bad_size && (map_from_fifo || map_from_fresh)) begin
                  size_we      = 1'b1;
                  size_wr_idx  = map_id;
                  size_wr_data = SZ_W'(size_ff);
               end
            end
            sgmu_pkg::OP_UNMAP: begin
               if (seg_known && size_a_ff != '0) begin
                  size_we = 1'b1;
                  fifo_we = 1'b1;
               end
            end
            sgmu_pkg::OP_COPY: begin
               if (seg_known && src_known && seg_ff != src_ff) begin
                  size_we      = 1'b1;
                  size_wr_data = size_q;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      size_q <= size_mem[size_rd_idx];
      fifo_q <= fifo_mem[head_ff];
      word_q <= word_mem[word_rd_addr];
      if (size_we) size_mem[size_wr_idx] <= size_wr_data;
      if (fifo_we) fifo_mem[tail_idx] <= seg_idx;
      if (word_we) word_mem[word_wr_addr] <= word_wr_data;
   end

   assign busy = state_ff != S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         fresh_ff    <= '0;
         rsp_valid   <= 1'b0;
         rsp_rd_data <= '0;
         rsp_status  <= sgmu_pkg::ST_OK;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= req_type;
                  seg_ff   <= req_seg_id;
                  src_ff   <= req_src_seg;
                  addr_ff  <= req_word_addr;
                  val_ff   <= req_wr_value;
                  size_ff  <= req_seg_size;
                  state_ff <= S_SZA;
               end
            end
            S_SZA: state_ff <= S_SZB;
            S_SZB: begin
               size_a_ff <= size_q;
               state_ff  <= S_EXEC;
            end
            S_EXEC: begin
               rsp_rd_data <= '0;
               rsp_status  <= sgmu_pkg::ST_OK;
               state_ff    <= S_IDLE;
               rsp_valid   <= 1'b1;
               off_ff      <= '0;
               dst_base_ff <= ST_W'(seg_idx) * ST_W'(MAX_WORDS);
               src_base_ff <= ST_W'(src_idx) * ST_W'(MAX_WORDS);
               case (op_ff)
                  sgmu_pkg::OP_MAP: begin
                     if (map_bad_size) begin
                        rsp_status <= sgmu_pkg::ST_BADSIZE;
                     end else if (!map_from_fifo && !map_from_fresh) begin
                        rsp_status <= sgmu_pkg::ST_NOID;
                     end else begin
                        if (map_from_fifo) begin
                           head_ff  <= (head_ff == SEG_W'(MAX_SEGS - 1)) ? '0
                                       : head_ff + 1'b1;
                           count_ff <= count_ff - 1'b1;
                        end else begin
                           fresh_ff <= fresh_ff + 1'b1;
                        end
                        rsp_rd_data <= 32'(map_id);
                        dst_base_ff <= ST_W'(map_id) * ST_W'(MAX_WORDS);
                        len_ff      <= SZ_W'(size_ff);
                        rsp_valid   <= 1'b0;
                        state_ff    <= S_CLR;
                     end
                  end
                  sgmu_pkg::OP_UNMAP: begin
                     if (!seg_known || size_a_ff == '0) begin
                        rsp_status <= sgmu_pkg::ST_BADSEG;
                     end else begin
                        count_ff <= count_ff + 1'b1;
                     end
                  end
                  sgmu_pkg::OP_READ, sgmu_pkg::OP_WRITE: begin
                     if (!seg_known) begin
                        rsp_status <= sgmu_pkg::ST_BADSEG;
                     end else if (addr_ff >= 32'(size_a_ff)) begin
                        rsp_status <= sgmu_pkg::ST_BADADDR;
                     end else begin
                        off_ff    <= SZ_W'(addr_ff);
                        rsp_valid <= 1'b0;
                        state_ff  <= (op_ff == sgmu_pkg::OP_READ) ? S_RDA : S_WRW;
                     end
                  end
                  sgmu_pkg::OP_COPY: begin
                     if (!seg_known || !src_known) begin
                        rsp_status <= sgmu_pkg::ST_BADSEG;
                     end else if (seg_ff != src_ff) begin
                        // words past the source size are never readable
                        len_ff    <= size_q;
                        rsp_valid <= 1'b0;
                        state_ff  <= S_CPR;
                     end
                  end
                  sgmu_pkg::OP_VALIDATE: begin
                     rsp_rd_data <= 32'(seg_known && addr_ff < 32'(size_a_ff));
                  end
                  default: ;
               endcase
            end
            S_CLR: begin
               if (off_ff == len_ff) begin
                  rsp_valid <= 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  off_ff <= off_ff + 1'b1;
               end
            end
            S_CPR: begin
               if (off_ff == len_ff) begin
                  rsp_valid <= 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  state_ff <= S_CPW;
               end
            end
            S_CPW: begin
               off_ff   <= off_ff + 1'b1;
               state_ff <= S_CPR;
            end
            S_RDA: state_ff <= S_RDD;
            S_RDD: begin
               rsp_rd_data <= 32'(word_q);
               rsp_valid   <= 1'b1;
               state_ff    <= S_IDLE;
            end
            S_WRW: begin
               rsp_valid <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/sgmu_checker.sv =====
// sgmu_checker: port-level checks of segmented_memory_unit, bound to it here
// depends on sgmu_pkg
module sgmu_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_rd_data,
   input logic [2:0]  rsp_status
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after transfer");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("request ended without result");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sgmu_pkg::ST_OK |-> rsp_rd_data == 32'd0)
      else $error("error result carries data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= sgmu_pkg::ST_NOID) else $error("bad status code");

endmodule

bind segmented_memory_unit sgmu_checker u_sgmu_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_rd_data(rsp_rd_data), .rsp_status(rsp_status)
);

// ===== tb/segmented_memory_unit_tb.sv =====
// segmented_memory_unit_tb: self-checking bench for the segmented memory unit
// drives map, unmap, read, write, copy and validate requests, predicts each result
// depends on sgmu_pkg and segmented_memory_unit
`timescale 1ns / 1ps

module segmented_memory_unit_tb;

   localparam int SEGS        = 64;
   localparam int WORDS       = 256;
   localparam int STALL_LIMIT = 5000;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   typedef struct packed {
      logic [31:0] rd_data;
      logic [2:0]  status;
   } rsp_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_type;
   logic [31:0] req_seg_id;
   logic [31:0] req_src_seg;
   logic [31:0] req_word_addr;
   logic [31:0] req_wr_value;
   logic [31:0] req_seg_size;
   logic        rsp_valid;
   logic [31:0] rsp_rd_data;
   logic [2:0]  rsp_status;

   // shadow of the block's state
   logic [31:0] shadow_words [0:SEGS*WORDS-1];
   logic [8:0]  shadow_len [0:SEGS-1];
   logic [5:0]  shadow_ring [0:SEGS-1];
   int unsigned ring_head;
   int unsigned ring_count;
   logic [31:0] fresh_id;

   rsp_t pending_rsp [$];
   int   error_count;
   int   sent_count;
   int   rsp_count;
   int   idle_pct;
   int   quiet_cycles;

   segmented_memory_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_seg_id    (req_seg_id),
      .req_src_seg   (req_src_seg),
      .req_word_addr (req_word_addr),
      .req_wr_value  (req_wr_value),
      .req_seg_size  (req_seg_size),
      .rsp_valid     (rsp_valid),
      .rsp_rd_data   (rsp_rd_data),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic predict_request(input logic [2:0] kind, input logic [31:0] seg,
                                  input logic [31:0] src, input logic [31:0] addr,
                                  input logic [31:0] val, input logic [31:0] size,
                                  output rsp_t r);
      logic [5:0] id;
      r.rd_data = '0;
      r.status  = sgmu_pkg::ST_OK;
      case (kind)
         sgmu_pkg::OP_MAP: begin
            if (size == 0 || size > WORDS) begin
               r.status = sgmu_pkg::ST_BADSIZE;
            end else if (ring_count == 0 && fresh_id >= SEGS) begin
               r.status = sgmu_pkg::ST_NOID;
            end else begin
               if (ring_count > 0) begin
                  id = shadow_ring[ring_head];
                  ring_head = (ring_head + 1) % SEGS;
                  ring_count--;
               end else begin
                  id = fresh_id[5:0];
                  fresh_id++;
               end
               shadow_len[id] = size[8:0];
               for (int i = 0; i < WORDS; i++) shadow_words[id*WORDS+i] = '0;
               r.rd_data = {26'b0, id};
            end
         end
         sgmu_pkg::OP_UNMAP: begin
            if (seg >= fresh_id || shadow_len[seg[5:0]] == 0) begin
               r.status = sgmu_pkg::ST_BADSEG;
            end else begin
               shadow_len[seg[5:0]] = '0;
               shadow_ring[(ring_head + ring_count) % SEGS] = seg[5:0];
               ring_count++;
            end
         end
         sgmu_pkg::OP_READ, sgmu_pkg::OP_WRITE: begin
            if (seg >= fresh_id) r.status = sgmu_pkg::ST_BADSEG;
            else if (addr >= shadow_len[seg[5:0]]) r.status = sgmu_pkg::ST_BADADDR;
            else if (kind == sgmu_pkg::OP_READ)
               r.rd_data = shadow_words[seg[5:0]*WORDS+addr[7:0]];
            else shadow_words[seg[5:0]*WORDS+addr[7:0]] = val;
         end
         sgmu_pkg::OP_COPY: begin
            if (src >= fresh_id || seg >= fresh_id) begin
               r.status = sgmu_pkg::ST_BADSEG;
            end else if (src != seg) begin
               shadow_len[seg[5:0]] = shadow_len[src[5:0]];
               for (int i = 0; i < WORDS; i++)
                  shadow_words[seg[5:0]*WORDS+i] = shadow_words[src[5:0]*WORDS+i];
            end
         end
         sgmu_pkg::OP_VALIDATE: begin
            r.rd_data = (seg < fresh_id && addr < shadow_len[seg[5:0]]) ? 32'd1 : 32'd0;
         end
         default: ;
      endcase
   endtask

   // start stays high between back-to-back transfers; it is lowered only for a gap
   task automatic send_request(input logic [2:0] kind, input logic [31:0] seg,
                               input logic [31:0] src, input logic [31:0] addr,
                               input logic [31:0] val, input logic [31:0] size);
      rsp_t r;
      start         <= 1'b1;
      req_type      <= kind;
      req_seg_id    <= seg;
      req_src_seg   <= src;
      req_word_addr <= addr;
      req_wr_value  <= val;
      req_seg_size  <= size;
      do @(posedge clock); while (busy);
      predict_request(kind, seg, src, addr, val, size, r);
      pending_rsp.push_back(r);
      sent_count++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold off the sender until every expected result has come back
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_t exp_rsp;
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $error("result with nothing expected: rd_data %h status %0d",
                   rsp_rd_data, rsp_status);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_rd_data !== exp_rsp.rd_data) begin
               $error("rd_data: expected %h actual %h", exp_rsp.rd_data, rsp_rd_data);
               error_count++;
            end
            if (rsp_status !== exp_rsp.status) begin
               $error("status: expected %0d actual %0d", exp_rsp.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("** segmented_memory_unit: FAILED **");
         $finish;
      end
   end

   function automatic logic [31:0] pick_seg();
      if (fresh_id != 0 && $urandom_range(99) < 85) return $urandom_range(fresh_id - 1);
      if ($urandom_range(1)) return $urandom;
      return fresh_id + $urandom_range(3);
   endfunction

   function automatic logic [31:0] pick_addr(input logic [31:0] seg);
      int unsigned len;
      len = (seg < fresh_id) ? shadow_len[seg[5:0]] : 4;
      if ($urandom_range(99) < 80) return $urandom_range(len + 1);
      return $urandom;
   endfunction

   task automatic test_directed;
      send_request(sgmu_pkg::OP_VALIDATE, 0, 0, 0, 0, 0);
      send_request(sgmu_pkg::OP_READ, 0, 0, 0, 0, 0);
      send_request(sgmu_pkg::OP_UNMAP, 0, 0, 0, 0, 0);
      send_request(sgmu_pkg::OP_MAP, 0, 0, 0, 0, 0);
      send_request(sgmu_pkg::OP_MAP, 0, 0, 0, 0, WORDS + 1);
      send_request(sgmu_pkg::OP_MAP, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_request(sgmu_pkg::OP_MAP, 0, 0, 0, 0, 1);
      send_request(sgmu_pkg::OP_MAP, 0, 0, 0, 0, WORDS);
      send_request(sgmu_pkg::OP_WRITE, 1, 0, WORDS - 1, 32'hFFFF_FFFF, 0);
      send_request(sgmu_pkg::OP_READ, 1, 0, WORDS - 1, 0, 0);
      send_request(sgmu_pkg::OP_READ, 1, 0, WORDS, 0, 0);
      send_request(sgmu_pkg::OP_WRITE, 1, 0, 32'hFFFF_FFFF, 32'h1234_5678, 0);
      send_request(sgmu_pkg::OP_WRITE, 1, 0, 0, 32'hA5A5_5A5A, 0);
      send_request(sgmu_pkg::OP_COPY, 1, 1, 0, 0, 0);
      send_request(sgmu_pkg::OP_COPY, 0, 1, 0, 0, 0);
      send_request(sgmu_pkg::OP_READ, 0, 0, WORDS - 1, 0, 0);
      send_request(sgmu_pkg::OP_VALIDATE, 0, 0, WORDS - 1, 0, 0);
      send_request(sgmu_pkg::OP_VALIDATE, 0, 0, WORDS, 0, 0);
      send_request(sgmu_pkg::OP_READ, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send_request(sgmu_pkg::OP_COPY, 0, 32'hFFFF_FFFF, 0, 0, 0);
      send_request(sgmu_pkg::OP_UNMAP, 0, 0, 0, 0, 0);
      send_request(sgmu_pkg::OP_READ, 0, 0, 0, 0, 0);
      send_request(sgmu_pkg::OP_UNMAP, 0, 0, 0, 0, 0);
      // freed source leaves the destination empty but not on the free ring
      send_request(sgmu_pkg::OP_COPY, 1, 0, 0, 0, 0);
      send_request(sgmu_pkg::OP_UNMAP, 1, 0, 0, 0, 0);
      send_request(sgmu_pkg::OP_MAP, 0, 0, 0, 0, 2);
      send_request(OP_RSVD6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_RSVD7, 0, 0, 0, 0, 0);
      drain();
   endtask

   task automatic test_exhaust_ids;
      for (int i = 0; i < SEGS + 2; i++)
         send_request(sgmu_pkg::OP_MAP, 0, 0, 0, 0, $urandom_range(1, 4));
      for (int i = 0; i < 6; i++)
         send_request(sgmu_pkg::OP_UNMAP, $urandom_range(SEGS - 1), 0, 0, 0, 0);
      drain();
   endtask

   task automatic test_random(input int count, input int pct);
      logic [2:0]  kind;
      logic [31:0] seg;
      logic [31:0] size;
      int          pick;
      idle_pct = pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         seg  = pick_seg();
         size = $urandom_range(1, 8);
         if (pick < 10) begin
            kind = sgmu_pkg::OP_MAP;
            if ($urandom_range(19) == 0) size = WORDS;
            else if ($urandom_range(19) == 0) size = $urandom;
         end else if (pick < 18) kind = sgmu_pkg::OP_UNMAP;
         else if (pick < 43) kind = sgmu_pkg::OP_READ;
         else if (pick < 70) kind = sgmu_pkg::OP_WRITE;
         else if (pick < 77) kind = sgmu_pkg::OP_COPY;
         else if (pick < 97) kind = sgmu_pkg::OP_VALIDATE;
         else kind = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
         send_request(kind, seg, pick_seg(), pick_addr(seg), $urandom, size);
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = sgmu_pkg::OP_MAP;
      req_seg_id = '0;
      req_src_seg = '0;
      req_word_addr = '0;
      req_wr_value = '0;
      req_seg_size = '0;
      error_count = 0;
      sent_count = 0;
      rsp_count = 0;
      idle_pct = 0;
      ring_head = 0;
      ring_count = 0;
      fresh_id = '0;
      for (int i = 0; i < SEGS; i++) shadow_len[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_exhaust_ids();
      test_random(90, 0);
      test_random(90, 76);
      test_random(90, 0);
      test_random(90, 31);

      $display("covered %0d requests, %0d results: error statuses, id exhaustion and reuse,",
               sent_count, rsp_count);
      $display("copies including self and freed sources, under several sender gap rates");
      if (error_count == 0) begin
         $display("** segmented_memory_unit: PASSED **");
      end else begin
         $display("** segmented_memory_unit: FAILED **");
      end
      $finish;
   end

endmodule
